// ===== hw/rtl/btn_pkg.sv =====
// Shared types and constants for the bounded top-N sorted list.
// Used by btn_cell and bounded_top_n_sorted_list; depends on nothing.

package btn_pkg;

	localparam int OP_W     = 2;
	localparam int KIND_W   = 2;
	localparam int CAP_W    = 4;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERTED  = 2'd0,
		KIND_DISCARDED = 2'd1,
		KIND_ENTRY     = 2'd2,
		KIND_EMPTY     = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LARGEST = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	typedef struct packed {
		logic ins_en;
		logic rot_en;
		logic occ;
		logic at_slot;
		logic tail;
	} btn_cell_ctl_t;

endpackage

// ===== hw/rtl/btn_cell.sv =====
// One slot of the sorted list: holds a key and payload, compares against a new key.
// Depends on btn_pkg for the cell control struct.

module btn_cell #(
	parameter int KEY_WIDTH     = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                            clk,
	input  btn_pkg::btn_cell_ctl_t          ctl,
	input  logic                            keep_largest,
	input  logic signed [KEY_WIDTH-1:0]     new_key,
	input  logic        [PAYLOAD_WIDTH-1:0] new_payload,
	input  logic                            prev_worse,
	input  logic signed [KEY_WIDTH-1:0]     prev_key,
	input  logic        [PAYLOAD_WIDTH-1:0] prev_payload,
	input  logic signed [KEY_WIDTH-1:0]     next_key,
	input  logic        [PAYLOAD_WIDTH-1:0] next_payload,
	input  logic signed [KEY_WIDTH-1:0]     head_key,
	input  logic        [PAYLOAD_WIDTH-1:0] head_payload,
	output logic                            worse,
	output logic signed [KEY_WIDTH-1:0]     slot_key,
	output logic        [PAYLOAD_WIDTH-1:0] slot_payload
);
	import btn_pkg::*;

	logic signed [KEY_WIDTH-1:0]     key_q;
	logic        [PAYLOAD_WIDTH-1:0] payload_q;
	logic                            cmp_worse;

	always_comb begin
		if (keep_largest) begin
			cmp_worse = key_q < new_key;
		end else begin
			cmp_worse = key_q > new_key;
		end
	end

	// Every occupied cell from the first strictly worse entry onward shifts down by one.
	assign worse        = ctl.occ && (cmp_worse || prev_worse);
	assign slot_key     = key_q;
	assign slot_payload = payload_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en && (worse || ctl.at_slot)) begin
			if (prev_worse) begin
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end else begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end else if (ctl.rot_en && ctl.occ) begin
			if (ctl.tail) begin
				key_q     <= head_key;
				payload_q <= head_payload;
			end else begin
				key_q     <= next_key;
				payload_q <= next_payload;
			end
		end
	end

endmodule

// ===== hw/rtl/bounded_top_n_sorted_list.sv =====
// Top level of the bounded top-N sorted list: control, fill count and the chain of cells.
// Depends on btn_pkg and btn_cell.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------
//  in      | in_valid  | in_stall  | op, key, payload
//  out     | out_valid | out_stall | kind, entry_key, entry_payload, last
//  cfg     | cfg_we    | none      | cfg_index, cfg_data
//
// Insert and clear each return a single result; each cell compares the new key in parallel.
// A read returns each stored entry in turn, starting from cell 0: the chain rotates
// toward cell 0 once per entry while the output is not stalled.
// Reset empties the list and restores capacity 8 and keep_largest 1.
// A stall on the output holds the result register and stalls the input.

module bounded_top_n_sorted_list #(
	parameter int DEPTH         = 8,
	parameter int PAYLOAD_WIDTH = 32,
	parameter int KEY_WIDTH     = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [btn_pkg::OP_W-1:0]            op,
	input  logic signed [KEY_WIDTH-1:0]         key,
	input  logic [PAYLOAD_WIDTH-1:0]            payload,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [btn_pkg::KIND_W-1:0]          kind,
	output logic signed [KEY_WIDTH-1:0]         entry_key,
	output logic [PAYLOAD_WIDTH-1:0]            entry_payload,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [btn_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [btn_pkg::CAP_W-1:0]           cfg_data
);
	import btn_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

	state_t                       state_q, state_nx;
	logic [FW-1:0]                fill_q;
	logic [IW-1:0]                rd_q;
	logic [CAP_W-1:0]             cap_q;
	logic                         keep_largest_q;

	logic                         out_valid_q;
	kind_t                        kind_q;
	logic signed [KEY_WIDTH-1:0]  key_q;
	logic [PAYLOAD_WIDTH-1:0]     payload_q;
	logic                         last_q;

	logic [FW-1:0]                cap_eff;
	logic                         full;
	logic                         any_worse;
	logic                         discard;
	logic                         out_free;
	logic                         acc;
	logic                         ins_en;
	logic                         rot_en;
	logic                         rd_last;
	logic                         rd_start;
	op_t                          op_e;

	logic [DEPTH-1:0]             worse;
	logic signed [KEY_WIDTH-1:0]  cell_key [DEPTH];
	logic [PAYLOAD_WIDTH-1:0]     cell_payload [DEPTH];

	assign op_e      = op_t'(op);
	assign out_free  = !out_valid_q || !out_stall;
	assign acc       = in_valid && !in_stall;
	assign any_worse = |worse;
	assign full      = fill_q >= cap_eff;
	assign discard   = full && !any_worse;
	assign ins_en    = acc && (op_e == OP_INSERT) && !discard;
	assign rd_last   = FW'(rd_q) == (fill_q - FW'(1));
	assign rd_start  = acc && (op_e == OP_READ) && (fill_q != '0);

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = FW'(1);
		end else if (32'(cap_q) > DEPTH) begin
			cap_eff = DEPTH_F;
		end else begin
			cap_eff = FW'(cap_q);
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (rd_start) begin
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				if (out_free && rd_last) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rot_en   = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = !out_free;
			ST_READ: rot_en = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			rd_q           <= '0;
			cap_q          <= CAP_RESET;
			keep_largest_q <= 1'b1;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				if (cfg_index == CFG_CAPACITY) begin
					cap_q <= cfg_data;
				end else if (cfg_index == CFG_KEEP_LARGEST) begin
					keep_largest_q <= cfg_data[0];
				end
			end
			if (ins_en && !full) begin
				fill_q <= fill_q + FW'(1);
			end else if (acc && (op_e == OP_CLEAR)) begin
				fill_q <= '0;
			end
			if (rd_start) begin
				rd_q <= '0;
			end else if (rot_en) begin
				rd_q <= rd_q + IW'(1);
			end
			if (acc && (op_e == OP_INSERT || op_e == OP_READ || op_e == OP_CLEAR)) begin
				out_valid_q <= !rd_start;
			end else if (rot_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rot_en) begin
			kind_q    <= KIND_ENTRY;
			key_q     <= cell_key[0];
			payload_q <= cell_payload[0];
			last_q    <= rd_last;
		end else if (acc) begin
			key_q     <= '0;
			payload_q <= '0;
			last_q    <= 1'b1;
			if (op_e == OP_INSERT) begin
				kind_q <= discard ? KIND_DISCARDED : KIND_INSERTED;
			end else begin
				kind_q <= KIND_EMPTY;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign entry_key     = key_q;
	assign entry_payload = payload_q;
	assign last          = last_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		btn_cell_ctl_t                ctl;
		logic                         prev_worse;
		logic signed [KEY_WIDTH-1:0]  prev_key;
		logic [PAYLOAD_WIDTH-1:0]     prev_payload;
		logic signed [KEY_WIDTH-1:0]  next_key;
		logic [PAYLOAD_WIDTH-1:0]     next_payload;

		assign ctl.ins_en  = ins_en;
		assign ctl.rot_en  = rot_en;
		assign ctl.occ     = FW'(i) < fill_q;
		assign ctl.at_slot = (FW'(i) == fill_q) && !full;
		assign ctl.tail    = FW'(i) == (fill_q - FW'(1));

		if (i == 0) begin : g_first
			assign prev_worse   = 1'b0;
			assign prev_key     = '0;
			assign prev_payload = '0;
		end else begin : g_mid
			assign prev_worse   = worse[i-1];
			assign prev_key     = cell_key[i-1];
			assign prev_payload = cell_payload[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign next_key     = cell_key[0];
			assign next_payload = cell_payload[0];
		end else begin : g_inner
			assign next_key     = cell_key[i+1];
			assign next_payload = cell_payload[i+1];
		end

		btn_cell #(
			.KEY_WIDTH     (KEY_WIDTH),
			.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
		) u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.keep_largest (keep_largest_q),
			.new_key      (key),
			.new_payload  (payload),
			.prev_worse   (prev_worse),
			.prev_key     (prev_key),
			.prev_payload (prev_payload),
			.next_key     (next_key),
			.next_payload (next_payload),
			.head_key     (cell_key[0]),
			.head_payload (cell_payload[0]),
			.worse        (worse[i]),
			.slot_key     (cell_key[i]),
			.slot_payload (cell_payload[i])
		);
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("Fill count exceeds the number of cells.");

	a_read_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> in_stall)
		else $error("Input accepted during a list read-out.");

	a_read_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && out_free && rd_last) |=> state_q == ST_IDLE)
		else $error("Read-out did not end after the last entry.");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ins_en && !full) |=> fill_q == $past(fill_q) + FW'(1))
		else $error("Insert into a list with room did not grow the fill count.");
`endif

endmodule
